FILE: hdl/rvmt_pkg.sv
package rvmt_pkg;

  localparam int LANES         = 4;
  localparam int ELEM_W        = 32;
  localparam int ROW_W         = 2;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int DEF_DIM       = 4;
  localparam int DEF_FRAC_BITS = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                          en;
    logic [ROW_W-1:0]              row;
    logic [LANES-1:0][ELEM_W-1:0]  data;
  } coef_wr_t;

endpackage

FILE: hdl/rvmt_if.sv
interface rvmt_in_if;
  import rvmt_pkg::*;

  logic             valid;
  logic             ready;
  cmd_t             cmd;
  logic [ROW_W-1:0] row_sel;
  elem_t            elem0;
  elem_t            elem1;
  elem_t            elem2;
  elem_t            elem3;

  modport source (output valid, cmd, row_sel, elem0, elem1, elem2, elem3, input ready);
  modport sink   (input valid, cmd, row_sel, elem0, elem1, elem2, elem3, output ready);
endinterface

interface rvmt_out_if;
  import rvmt_pkg::*;

  logic  valid;
  logic  ready;
  elem_t res0;
  elem_t res1;
  elem_t res2;
  elem_t res3;
  logic  sat_flag;

  modport source (output valid, res0, res1, res2, res3, sat_flag, input ready);
  modport sink   (input valid, res0, res1, res2, res3, sat_flag, output ready);
endinterface

FILE: hdl/row_vector_matrix_transform.sv
// Row vector times 4x4 Q16.16 matrix. A load transfer (cmd 0) writes one matrix row and
// produces no result; a load to a row at or beyond DIM is dropped. A transform transfer
// (cmd 1) produces one result whose lane c is the exact dot product of the vector with
// matrix column c, shifted right by FRAC_BITS with floor rounding and saturated to
// 32 bits; sat_flag marks any clamped lane, and lanes at or beyond DIM read zero.
// The block takes one transfer per clock while its output is not stalled. A result passes
// through the input register, a stage of sixteen registered 32x32 products, and the adder
// tree with saturation into the output register. Rows are written in transfer order, so a
// transform sees every load accepted before it. The matrix clears to zero at reset.
module row_vector_matrix_transform #(
  parameter int DIM       = rvmt_pkg::DEF_DIM,
  parameter int FRAC_BITS = rvmt_pkg::DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rvmt_in_if.sink    in_ch,
  rvmt_out_if.source out_ch
);
  import rvmt_pkg::*;

  logic             s1_v_r;
  logic             s1_v_nxt;
  cmd_t             s1_cmd_r;
  logic [ROW_W-1:0] s1_row_r;
  elem_t            s1_vec_r [DIM];
  elem_t            in_vec   [LANES];
  logic             s2_v_r;
  logic             s2_v_nxt;
  logic             out_v_r;
  logic             out_v_nxt;
  elem_t            res_r    [LANES];
  logic             sat_r;

  logic             rdy1;
  logic             rdy2;
  logic             rdy3;
  logic             in_fire;
  logic             s1_move;
  logic             s2_move;
  logic             lane_adv;
  coef_wr_t         coef_wr;

  elem_t            coef     [DIM][DIM];
  elem_t            coef_col [DIM][DIM];
  elem_t            lane_res [DIM];
  logic [DIM-1:0]   lane_sat;

  assign rdy3     = !out_v_r || out_ch.ready;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_fire  = in_ch.valid && rdy1;
  assign s1_move  = s1_v_r && rdy2;
  assign s2_move  = s2_v_r && rdy3;
  assign lane_adv = s1_move && (s1_cmd_r == CMD_XFORM);

  assign in_ch.ready = rdy1;

  assign in_vec[0] = in_ch.elem0;
  assign in_vec[1] = in_ch.elem1;
  assign in_vec[2] = in_ch.elem2;
  assign in_vec[3] = in_ch.elem3;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end

    s2_v_nxt = s2_v_r;
    if (s1_move) begin
      s2_v_nxt = (s1_cmd_r == CMD_XFORM);
    end else if (s2_move) begin
      s2_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (s2_move) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_ch.cmd;
      s1_row_r <= in_ch.row_sel;
      for (int k = 0; k < DIM; k++) begin
        s1_vec_r[k] <= in_vec[k];
      end
    end
  end

  // Loads commit as they leave the input register, so later transforms see them.
  always_comb begin
    coef_wr.en   = s1_move && (s1_cmd_r == CMD_LOAD)
                   && ({1'b0, s1_row_r} < (ROW_W+1)'(DIM));
    coef_wr.row  = s1_row_r;
    coef_wr.data = '0;
    for (int k = 0; k < DIM; k++) begin
      coef_wr.data[k] = s1_vec_r[k];
    end
  end

  rvmt_coef_store #(
    .DIM (DIM)
  ) u_coef_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (coef_wr),
    .coef  (coef)
  );

  for (genvar c = 0; c < DIM; c++) begin : g_lane
    for (genvar k = 0; k < DIM; k++) begin : g_tap
      assign coef_col[c][k] = coef[k][c];
    end

    rvmt_mac_lane #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk (clk),
      .adv (lane_adv),
      .vec (s1_vec_r),
      .col (coef_col[c]),
      .res (lane_res[c]),
      .sat (lane_sat[c])
    );

    always_ff @(posedge clk) begin
      if (s2_move) begin
        res_r[c] <= lane_res[c];
      end
    end
  end

  for (genvar c = DIM; c < LANES; c++) begin : g_unused
    assign res_r[c] = '0;
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      sat_r <= |lane_sat;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.res0     = res_r[0];
  assign out_ch.res1     = res_r[1];
  assign out_ch.res2     = res_r[2];
  assign out_ch.res3     = res_r[3];
  assign out_ch.sat_flag = sat_r;

endmodule

FILE: hdl/rvmt_coef_store.sv
module rvmt_coef_store #(
  parameter int DIM = rvmt_pkg::DEF_DIM
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rvmt_pkg::coef_wr_t wr,
  output rvmt_pkg::elem_t   coef [DIM][DIM]
);
  import rvmt_pkg::*;

  elem_t coef_r [DIM][DIM];

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          coef_r[r][c] <= '0;
        end else if (wr.en && (wr.row == ROW_W'(r))) begin
          coef_r[r][c] <= elem_t'(wr.data[c]);
        end
      end
      assign coef[r][c] = coef_r[r][c];
    end
  end

endmodule

FILE: hdl/rvmt_mac_lane.sv
module rvmt_mac_lane #(
  parameter int DIM       = rvmt_pkg::DEF_DIM,
  parameter int FRAC_BITS = rvmt_pkg::DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            adv,
  input  rvmt_pkg::elem_t vec [DIM],
  input  rvmt_pkg::elem_t col [DIM],
  output rvmt_pkg::elem_t res,
  output logic            sat
);
  import rvmt_pkg::*;

  prod_t prod_r   [DIM];
  prod_t prod_nxt [DIM];
  acc_t  acc;
  acc_t  shifted;
  logic [ACC_W-ELEM_W:0] hi_bits;
  logic  pos_ovf;
  logic  neg_ovf;

  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      prod_nxt[k] = PROD_W'(vec[k]) * PROD_W'(col[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  // The exact sum is floored by the arithmetic shift, then clamped to 32 bits.
  always_comb begin
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      acc = acc + ACC_W'(prod_r[k]);
    end
    shifted = acc >>> FRAC_BITS;
    hi_bits = shifted[ACC_W-1:ELEM_W-1];
    pos_ovf = !shifted[ACC_W-1] && (|hi_bits);
    neg_ovf = shifted[ACC_W-1] && !(&hi_bits);
    sat     = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      res = {1'b0, {(ELEM_W-1){1'b1}}};
    end else if (neg_ovf) begin
      res = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res = shifted[ELEM_W-1:0];
    end
  end

endmodule
